[rtl/multichannel_pcm_mixer_assert.svh]
// Assertion macros used by the checker file of the mixer.
// Each macro needs clk, and all but the last rst_n, in scope.
`ifndef MULTICHANNEL_PCM_MIXER_ASSERT_SVH
`define MULTICHANNEL_PCM_MIXER_ASSERT_SVH

// Consequence must hold in the same cycle as the antecedent.
`define PCMMIX_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pcm mixer check failed");

// Consequence must hold in the cycle after the antecedent.
`define PCMMIX_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pcm mixer check failed");

// As above, but also checked while reset is applied.
`define PCMMIX_ASSERT_NXT_RST(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("pcm mixer check failed");

`endif

[rtl/pcmmix_pkg.sv]
`default_nettype none

package pcmmix_pkg;

  // Operation codes of a request.
  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_START = 2'd1;
  localparam logic [1:0] OP_WRITE = 2'd2;

  // Field widths fixed by the interface.
  localparam int OP_W        = 2;
  localparam int VOICE_W     = 3;
  localparam int LEVEL_W     = 7;
  localparam int RATE_W      = 16;
  localparam int COUNT_W     = 17;
  localparam int ADDR_W      = 16;
  localparam int BYTE_W      = 8;
  localparam int MASTER_W    = 2;
  localparam int ACTIVE_W    = 8;

  // Fixed-point layout of a voice position.
  localparam int POS_W       = 33;
  localparam int FRAC_BITS   = 16;
  localparam int DIVIDEND_W  = RATE_W + FRAC_BITS;

  localparam logic [COUNT_W-1:0]  MAX_COUNT     = 17'd65536;
  localparam logic [BYTE_W-1:0]   SILENCE       = 8'd128;
  localparam logic [MASTER_W-1:0] MASTER_RESET  = 2'd3;
  localparam int                  SHIFT_BASE    = 7 + 3;
  localparam int                  SAMPLE_MAX    = 255;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TICK,
    ST_DRAIN,
    ST_MIX,
    ST_DIV,
    ST_DONE
  } state_t;

endpackage

`default_nettype wire

[rtl/pcmmix_ram.sv]
`default_nettype none

module pcmmix_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                                   clk,
  input  wire logic                                   wr_en,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]                       wr_data,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic      [WIDTH-1:0]                       rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

[rtl/pcmmix_step_div.sv]
`default_nettype none

// Phase step: a 16.16 rate divided by the fixed output rate. A scaled reciprocal
// gives an estimate that is at most one short; a compare and subtract in the
// next step corrects it.
module pcmmix_step_div #(
  parameter int DIVISOR = 14016,
  parameter int Q_W     = 19
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                start,
  input  wire logic [pcmmix_pkg::RATE_W-1:0]       rate,
  output logic                                     busy,
  output logic      [Q_W-1:0]                      quotient
);
  import pcmmix_pkg::*;

  localparam longint RECIP   = (64'd1 << DIVIDEND_W) / DIVISOR;
  localparam int     RECIP_W = $clog2(RECIP + 1);
  localparam int     DIV_W   = $clog2(DIVISOR + 1);

  logic                      busy_r, busy_nxt;
  logic                      fix_r, fix_nxt;
  logic [RATE_W-1:0]         rate_r, rate_nxt;
  logic [Q_W-1:0]            quo_r, quo_nxt;
  logic [RATE_W+RECIP_W-1:0] scaled;
  logic [Q_W+DIV_W-1:0]      back;
  logic [DIVIDEND_W-1:0]     rem;
  logic                      fits;

  assign scaled = rate_r * RECIP_W'(RECIP);
  // The estimate never exceeds the true quotient, so its product fits the dividend.
  assign back   = quo_r * DIV_W'(DIVISOR);
  assign rem    = {rate_r, FRAC_BITS'(0)} - DIVIDEND_W'(back);
  assign fits   = rem >= DIVIDEND_W'(DIVISOR);

  always_comb begin
    busy_nxt = busy_r;
    fix_nxt  = fix_r;
    rate_nxt = rate_r;
    quo_nxt  = quo_r;
    if (start) begin
      busy_nxt = 1'b1;
      fix_nxt  = 1'b0;
      rate_nxt = rate;
    end else if (busy_r && !fix_r) begin
      quo_nxt = Q_W'(scaled >> RATE_W);
      fix_nxt = 1'b1;
    end else if (busy_r) begin
      if (fits) begin
        quo_nxt = quo_r + 1'b1;
      end
      busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    fix_r  <= fix_nxt;
    rate_r <= rate_nxt;
    quo_r  <= quo_nxt;
  end

  assign busy     = busy_r;
  assign quotient = quo_r;

endmodule

`default_nettype wire

[rtl/multichannel_pcm_mixer.sv]
`default_nettype none

// Channel   Direction  Handshake              Payload
// in_       input      in_valid / in_ready    operation, voice, level, rate, count,
//                                             address, sample byte
// out_      output     out_valid / out_ready  mixed sample, start accepted, active voices
// cfg_      input      cfg_wr_en              cfg_wr_data (master volume)
//
// One request at a time; every request gives exactly one result.
// Tick: walks the voice table one entry a cycle, with one sample memory read
// per voice. Start: waits for the step calculation, which a rejected start
// skips. Write and unused codes go straight to the result.
// Reset is synchronous; the sample memory is not cleared and needs no pass.
// A result waiting in the output register does not stop the next request being
// taken; only a second finished result waits until out_ready.
module multichannel_pcm_mixer #(
  parameter int NUM_VOICES       = 8,
  parameter int SAMPLE_ADDR_BITS = 16,
  parameter int OUTPUT_RATE_HZ   = 14016
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                cfg_wr_en,
  input  wire logic [pcmmix_pkg::MASTER_W-1:0]     cfg_wr_data,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic [pcmmix_pkg::OP_W-1:0]         in_operation,
  input  wire logic [pcmmix_pkg::VOICE_W-1:0]      in_voice,
  input  wire logic [pcmmix_pkg::LEVEL_W-1:0]      in_level,
  input  wire logic [pcmmix_pkg::RATE_W-1:0]       in_sample_rate,
  input  wire logic [pcmmix_pkg::COUNT_W-1:0]      in_sample_count,
  input  wire logic [pcmmix_pkg::ADDR_W-1:0]       in_address,
  input  wire logic [pcmmix_pkg::BYTE_W-1:0]       in_sample_byte,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic      [pcmmix_pkg::BYTE_W-1:0]       out_mixed_sample,
  output logic                                     out_start_accepted,
  output logic      [pcmmix_pkg::ACTIVE_W-1:0]     out_active_voices
);
  import pcmmix_pkg::*;

  localparam int SAB      = SAMPLE_ADDR_BITS;
  localparam int VIDX_W   = NUM_VOICES > 1 ? $clog2(NUM_VOICES) : 1;
  localparam int STEP_W   = $clog2(((64'd65535 << FRAC_BITS) / OUTPUT_RATE_HZ) + 1);
  localparam int ACC_W    = 17 + $clog2(NUM_VOICES + 1);
  localparam int SM_DEPTH = 1 << SAB;

  // Voice table entry layout: {base, length, position, step, level}.
  localparam int LVL_LSB  = 0;
  localparam int STEP_LSB = LVL_LSB + LEVEL_W;
  localparam int POS_LSB  = STEP_LSB + STEP_W;
  localparam int LEN_LSB  = POS_LSB + POS_W;
  localparam int BASE_LSB = LEN_LSB + COUNT_W;
  localparam int VT_W     = BASE_LSB + SAB;

  state_t                   state_r, state_nxt;
  logic [MASTER_W-1:0]      master_r;
  logic [NUM_VOICES-1:0]    active_r, active_nxt;

  logic [VIDX_W-1:0]        st_voice_r, st_voice_nxt;
  logic [LEVEL_W-1:0]       st_level_r, st_level_nxt;
  logic [COUNT_W-1:0]       st_len_r, st_len_nxt;
  logic [SAB-1:0]           st_base_r, st_base_nxt;

  logic [VIDX_W-1:0]        rd_cnt_r, rd_cnt_nxt;
  logic                     s1_valid_r, s1_valid_nxt;
  logic [VIDX_W-1:0]        s1_vidx_r, s1_vidx_nxt;
  logic                     s2_valid_r, s2_valid_nxt;
  logic                     s2_hit_r, s2_hit_nxt;
  logic [LEVEL_W-1:0]       s2_level_r, s2_level_nxt;
  logic signed [ACC_W-1:0]  acc_r, acc_nxt;

  logic [BYTE_W-1:0]        res_mixed_r, res_mixed_nxt;
  logic                     res_start_r, res_start_nxt;

  logic                     out_valid_r, out_valid_nxt;
  logic [BYTE_W-1:0]        out_mixed_r, out_mixed_nxt;
  logic                     out_start_r, out_start_nxt;
  logic [ACTIVE_W-1:0]      out_active_r, out_active_nxt;

  logic                     vt_wr_en;
  logic [VIDX_W-1:0]        vt_wr_addr;
  logic [VT_W-1:0]          vt_wr_data;
  logic [VT_W-1:0]          vt_rd_data;
  logic                     sm_wr_en;
  logic [SAB-1:0]           sm_rd_addr;
  logic [BYTE_W-1:0]        sm_rd_data;

  logic                     div_start;
  logic                     div_busy;
  logic [STEP_W-1:0]        div_quotient;

  // Fields of the voice entry arriving from the table.
  logic [LEVEL_W-1:0]       s1_level;
  logic [STEP_W-1:0]        s1_step;
  logic [POS_W-1:0]         s1_pos;
  logic [COUNT_W-1:0]       s1_len;
  logic [SAB-1:0]           s1_base;
  logic [COUNT_W-1:0]       s1_idx;
  logic                     s1_act;
  logic                     s1_hit;

  logic signed [BYTE_W:0]   centred;
  logic signed [16:0]       product;
  logic signed [ACC_W-1:0]  shifted;
  logic signed [ACC_W:0]    offset;
  logic [BYTE_W-1:0]        mix_val;
  logic [ACTIVE_W-1:0]      active_view;
  logic [COUNT_W-1:0]       count_sat;
  logic                     start_ok;

  assign s1_level = vt_rd_data[LVL_LSB +: LEVEL_W];
  assign s1_step  = vt_rd_data[STEP_LSB +: STEP_W];
  assign s1_pos   = vt_rd_data[POS_LSB +: POS_W];
  assign s1_len   = vt_rd_data[LEN_LSB +: COUNT_W];
  assign s1_base  = vt_rd_data[BASE_LSB +: SAB];
  assign s1_idx   = s1_pos[POS_W-1:FRAC_BITS];
  assign s1_act   = s1_valid_r && active_r[s1_vidx_r];
  assign s1_hit   = s1_act && (s1_idx < s1_len);

  assign sm_rd_addr = s1_base + SAB'(s1_idx);

  assign centred = $signed({1'b0, sm_rd_data}) - $signed({1'b0, SILENCE});
  assign product = centred * $signed({1'b0, s2_level_r});

  // Arithmetic shift rounds towards minus infinity, as the mix requires.
  assign shifted = acc_r >>> (4'(SHIFT_BASE) - {2'b00, master_r});
  assign offset  = (ACC_W + 1)'(shifted) + $signed({1'b0, SILENCE});

  always_comb begin
    if (master_r == '0) begin
      mix_val = SILENCE;
    end else if (offset < 0) begin
      mix_val = '0;
    end else if (offset > SAMPLE_MAX) begin
      mix_val = BYTE_W'(SAMPLE_MAX);
    end else begin
      mix_val = offset[BYTE_W-1:0];
    end
  end

  for (genvar i = 0; i < ACTIVE_W; i++) begin : g_view
    if (i < NUM_VOICES) begin : g_on
      assign active_view[i] = active_r[i];
    end else begin : g_off
      assign active_view[i] = 1'b0;
    end
  end

  assign count_sat = (in_sample_count > MAX_COUNT) ? MAX_COUNT : in_sample_count;
  assign start_ok  = (in_sample_rate != '0) && (count_sat != '0) &&
                     (32'(in_voice) < NUM_VOICES);

  assign in_ready = (state_r == ST_IDLE);
  assign sm_wr_en = in_valid && in_ready && (in_operation == OP_WRITE);

  always_comb begin
    state_nxt      = state_r;
    active_nxt     = active_r;
    st_voice_nxt   = st_voice_r;
    st_level_nxt   = st_level_r;
    st_len_nxt     = st_len_r;
    st_base_nxt    = st_base_r;
    rd_cnt_nxt     = rd_cnt_r;
    s1_valid_nxt   = 1'b0;
    s1_vidx_nxt    = s1_vidx_r;
    s2_valid_nxt   = s1_valid_r;
    s2_hit_nxt     = s1_hit;
    s2_level_nxt   = s1_level;
    acc_nxt        = acc_r;
    res_mixed_nxt  = res_mixed_r;
    res_start_nxt  = res_start_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_mixed_nxt  = out_mixed_r;
    out_start_nxt  = out_start_r;
    out_active_nxt = out_active_r;
    vt_wr_en       = 1'b0;
    vt_wr_addr     = s1_vidx_r;
    vt_wr_data     = vt_rd_data;
    div_start      = 1'b0;

    // Second stage: the sample byte is back, add its weighted value.
    if (s2_valid_r && s2_hit_r) begin
      acc_nxt = acc_r + ACC_W'(product);
    end

    // First stage: a voice that has run out stops, a playing one advances.
    if (s1_act && !s1_hit) begin
      active_nxt[s1_vidx_r] = 1'b0;
    end
    if (s1_hit) begin
      vt_wr_en = 1'b1;
      vt_wr_data[POS_LSB +: POS_W] = s1_pos + POS_W'(s1_step);
    end

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          res_mixed_nxt = SILENCE;
          res_start_nxt = 1'b0;
          state_nxt     = ST_DONE;
          case (in_operation)
            OP_TICK: begin
              acc_nxt    = '0;
              rd_cnt_nxt = '0;
              state_nxt  = ST_TICK;
            end
            OP_START: begin
              st_voice_nxt = VIDX_W'(in_voice);
              st_level_nxt = in_level;
              st_len_nxt   = count_sat;
              st_base_nxt  = SAB'(in_address);
              if (start_ok) begin
                div_start = 1'b1;
                state_nxt = ST_DIV;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_TICK: begin
        s1_valid_nxt = 1'b1;
        s1_vidx_nxt  = rd_cnt_r;
        if (rd_cnt_r == VIDX_W'(NUM_VOICES - 1)) begin
          state_nxt = ST_DRAIN;
        end else begin
          rd_cnt_nxt = rd_cnt_r + 1'b1;
        end
      end
      ST_DRAIN: begin
        // The last voice leaves the second stage on this edge.
        if (s2_valid_r && !s1_valid_r) begin
          state_nxt = ST_MIX;
        end
      end
      ST_MIX: begin
        res_mixed_nxt = mix_val;
        state_nxt     = ST_DONE;
      end
      ST_DIV: begin
        if (!div_busy) begin
          vt_wr_en   = 1'b1;
          vt_wr_addr = st_voice_r;
          vt_wr_data = {st_base_r, st_len_r, POS_W'(0), div_quotient, st_level_r};
          active_nxt[st_voice_r] = 1'b1;
          res_start_nxt = 1'b1;
          state_nxt     = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_mixed_nxt  = res_mixed_r;
          out_start_nxt  = res_start_r;
          out_active_nxt = active_view;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      master_r    <= MASTER_RESET;
      active_r    <= '0;
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      active_r    <= active_nxt;
      s1_valid_r  <= s1_valid_nxt;
      s2_valid_r  <= s2_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        master_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    st_voice_r   <= st_voice_nxt;
    st_level_r   <= st_level_nxt;
    st_len_r     <= st_len_nxt;
    st_base_r    <= st_base_nxt;
    rd_cnt_r     <= rd_cnt_nxt;
    s1_vidx_r    <= s1_vidx_nxt;
    s2_hit_r     <= s2_hit_nxt;
    s2_level_r   <= s2_level_nxt;
    acc_r        <= acc_nxt;
    res_mixed_r  <= res_mixed_nxt;
    res_start_r  <= res_start_nxt;
    out_mixed_r  <= out_mixed_nxt;
    out_start_r  <= out_start_nxt;
    out_active_r <= out_active_nxt;
  end

  pcmmix_ram #(
    .WIDTH (VT_W),
    .DEPTH (NUM_VOICES)
  ) u_voice_ram (
    .clk     (clk),
    .wr_en   (vt_wr_en),
    .wr_addr (vt_wr_addr),
    .wr_data (vt_wr_data),
    .rd_addr (rd_cnt_r),
    .rd_data (vt_rd_data)
  );

  pcmmix_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (SM_DEPTH)
  ) u_sample_ram (
    .clk     (clk),
    .wr_en   (sm_wr_en),
    .wr_addr (SAB'(in_address)),
    .wr_data (in_sample_byte),
    .rd_addr (sm_rd_addr),
    .rd_data (sm_rd_data)
  );

  pcmmix_step_div #(
    .DIVISOR (OUTPUT_RATE_HZ),
    .Q_W     (STEP_W)
  ) u_step_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .rate     (in_sample_rate),
    .busy     (div_busy),
    .quotient (div_quotient)
  );

  assign out_valid          = out_valid_r;
  assign out_mixed_sample   = out_mixed_r;
  assign out_start_accepted = out_start_r;
  assign out_active_voices  = out_active_r;

endmodule

`default_nettype wire

[rtl/pcmmix_checker.sv]
`default_nettype none

`include "multichannel_pcm_mixer_assert.svh"

module pcmmix_checker (
  input wire logic                            clk,
  input wire logic                            rst_n,
  input wire logic                            out_valid,
  input wire logic                            out_ready,
  input wire logic [pcmmix_pkg::BYTE_W-1:0]   out_mixed_sample,
  input wire logic                            out_start_accepted,
  input wire logic [pcmmix_pkg::ACTIVE_W-1:0] out_active_voices
);
  import pcmmix_pkg::*;

  // A stalled result stays on offer.
  `PCMMIX_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid)

  // A voice that has just been loaded must show as playing.
  `PCMMIX_ASSERT_IMP(a_start_active, out_valid && out_start_accepted, out_active_voices != '0)

  // Only a tick produces a mix, and a tick never loads a voice.
  `PCMMIX_ASSERT_IMP(a_start_silent, out_valid && out_start_accepted,
                     out_mixed_sample == SILENCE)

  // Reset leaves no result on offer.
  `PCMMIX_ASSERT_NXT_RST(a_reset_empty, !rst_n, !out_valid)

endmodule

bind multichannel_pcm_mixer pcmmix_checker u_pcmmix_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_valid          (out_valid),
  .out_ready          (out_ready),
  .out_mixed_sample   (out_mixed_sample),
  .out_start_accepted (out_start_accepted),
  .out_active_voices  (out_active_voices)
);

`default_nettype wire
